/* design/v2d_pkg.sv */
// Package for the 2D vector unit: word types, mode and status codes,
// and the structs passed between the pipeline modules. No dependencies.
package v2d_pkg;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_SCALE = 3'd2;
    localparam logic [2:0] MODE_LEN   = 3'd3;
    localparam logic [2:0] MODE_NORM  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam int WORD_W   = 32;
    localparam int SQRT_STG = 32;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] scale_factor;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic [31:0]        magnitude;
        logic [1:0]         status;
    } t_out_word;

    // Component magnitudes of the first vector on their way to the root.
    typedef struct packed {
        logic        norm;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] m;
    } t_mag;

    // What the merge stage needs besides the root and the quotients.
    typedef struct packed {
        logic [2:0]         mode;
        logic               sx;
        logic               sy;
        logic               zero;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic [1:0]         status;
    } t_side;

endpackage

/* design/v2d_front.sv */
// Input stages of the vector unit: add, subtract and scale with saturation,
// and the component magnitudes. Depends on v2d_pkg.
module v2d_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  v2d_pkg::t_in_word i_item,
    output v2d_pkg::t_mag    o_mag,
    output v2d_pkg::t_side   o_side
);
    import v2d_pkg::*;

    logic [31:0]        mx;
    logic [31:0]        my;
    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_y;

    logic [2:0]         r_mode;
    logic               r_sx;
    logic               r_sy;
    logic               r_zero;
    logic signed [32:0] r_sum_x;
    logic signed [32:0] r_sum_y;
    logic signed [63:0] r_prod_x;
    logic signed [63:0] r_prod_y;
    t_mag               r_mag;
    t_side              r_side;
    t_side              n_side;

    logic signed [63:0] rnd_x;
    logic signed [63:0] rnd_y;
    logic               sat_ax;
    logic               sat_ay;
    logic               sat_sx;
    logic               sat_sy;

    assign mx = i_item.a_x[31] ? (~i_item.a_x + 32'd1) : i_item.a_x;
    assign my = i_item.a_y[31] ? (~i_item.a_y + 32'd1) : i_item.a_y;

    always_comb begin
        if (i_item.mode == MODE_SUB) begin
            sum_x = {i_item.a_x[31], i_item.a_x} - {i_item.b_x[31], i_item.b_x};
            sum_y = {i_item.a_y[31], i_item.a_y} - {i_item.b_y[31], i_item.b_y};
        end else begin
            sum_x = {i_item.a_x[31], i_item.a_x} + {i_item.b_x[31], i_item.b_x};
            sum_y = {i_item.a_y[31], i_item.a_y} + {i_item.b_y[31], i_item.b_y};
        end
    end

    assign prod_x = i_item.a_x * i_item.scale_factor;
    assign prod_y = i_item.a_y * i_item.scale_factor;

    always_ff @(posedge i_clk) begin
        r_mode     <= i_item.mode;
        r_sx       <= i_item.a_x[31];
        r_sy       <= i_item.a_y[31];
        r_zero     <= (mx == 32'd0) && (my == 32'd0);
        r_sum_x    <= sum_x;
        r_sum_y    <= sum_y;
        r_prod_x   <= prod_x;
        r_prod_y   <= prod_y;
        r_mag.norm <= (i_item.mode == MODE_NORM);
        r_mag.mx   <= mx;
        r_mag.my   <= my;
        r_mag.m    <= (mx > my) ? mx : my;
    end

    // Round half up: add one half, then floor by an arithmetic shift.
    assign rnd_x = (r_prod_x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rnd_y = (r_prod_y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign sat_sx = !((&rnd_x[63:31]) || !(|rnd_x[63:31]));
    assign sat_sy = !((&rnd_y[63:31]) || !(|rnd_y[63:31]));
    assign sat_ax = r_sum_x[32] != r_sum_x[31];
    assign sat_ay = r_sum_y[32] != r_sum_y[31];

    always_comb begin
        n_side.mode   = r_mode;
        n_side.sx     = r_sx;
        n_side.sy     = r_sy;
        n_side.zero   = r_zero;
        n_side.res_x  = '0;
        n_side.res_y  = '0;
        n_side.status = ST_OK;
        unique case (r_mode)
            MODE_ADD, MODE_SUB: begin
                if (sat_ax) begin
                    n_side.res_x = r_sum_x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    n_side.res_x = r_sum_x[31:0];
                end
                if (sat_ay) begin
                    n_side.res_y = r_sum_y[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    n_side.res_y = r_sum_y[31:0];
                end
                n_side.status = (sat_ax || sat_ay) ? ST_SAT : ST_OK;
            end
            MODE_SCALE: begin
                if (sat_sx) begin
                    n_side.res_x = rnd_x[63] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    n_side.res_x = rnd_x[31:0];
                end
                if (sat_sy) begin
                    n_side.res_y = rnd_y[63] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    n_side.res_y = rnd_y[31:0];
                end
                n_side.status = (sat_sx || sat_sy) ? ST_SAT : ST_OK;
            end
            default: begin
                n_side.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
    end

    assign o_mag  = r_mag;
    assign o_side = r_side;

endmodule

/* design/v2d_prep.sv */
// Normalizing shift (five binary steps), squaring and sum of squares ahead
// of the square root. Depends on v2d_pkg.
module v2d_prep (
    input  logic          i_clk,
    input  v2d_pkg::t_mag i_mag,
    output v2d_pkg::t_mag o_mag,
    output logic [63:0]   o_sum
);
    import v2d_pkg::*;

    localparam int NSH = 5;

    t_mag        r_st [NSH];
    t_mag        r_sq_mag;
    t_mag        r_sum_mag;
    logic [63:0] r_sqx;
    logic [63:0] r_sqy;
    logic [63:0] r_sum;
    logic [63:0] sqx;
    logic [63:0] sqy;

    // Step j shifts by 16 >> j in normalize mode when the shifted larger magnitude stays below 2^31.
    for (genvar j = 0; j < NSH; j++) begin : g_shift
        localparam int K = 16 >> j;
        t_mag prev;
        logic take;
        if (j == 0) begin : g_first
            assign prev = i_mag;
        end else begin : g_next
            assign prev = r_st[j-1];
        end
        assign take = prev.norm && ((prev.m >> (31 - K)) == 32'd0);
        always_ff @(posedge i_clk) begin
            r_st[j].norm <= prev.norm;
            r_st[j].mx   <= take ? (prev.mx << K) : prev.mx;
            r_st[j].my   <= take ? (prev.my << K) : prev.my;
            r_st[j].m    <= take ? (prev.m << K) : prev.m;
        end
    end

    assign sqx = r_st[NSH-1].mx * r_st[NSH-1].mx;
    assign sqy = r_st[NSH-1].my * r_st[NSH-1].my;

    always_ff @(posedge i_clk) begin
        r_sqx     <= sqx;
        r_sqy     <= sqy;
        r_sq_mag  <= r_st[NSH-1];
        r_sum     <= r_sqx + r_sqy;
        r_sum_mag <= r_sq_mag;
    end

    assign o_mag = r_sum_mag;
    assign o_sum = r_sum;

endmodule

/* design/v2d_sqrt.sv */
// Pipelined integer square root, one root bit per stage, 32 stages.
// Depends on v2d_pkg.
module v2d_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_v,
    output logic [31:0] o_root
);
    import v2d_pkg::*;

    logic [33:0] r_rem  [SQRT_STG];
    logic [31:0] r_root [SQRT_STG];
    logic [63:0] r_v    [SQRT_STG];

    for (genvar j = 0; j < SQRT_STG; j++) begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] v_in;
        logic [35:0] rem_t;
        logic [35:0] trial;
        logic        ge;
        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = i_v;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign v_in    = r_v[j-1];
        end
        assign rem_t = {rem_in, v_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = rem_t >= trial;
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= ge ? 34'(rem_t - trial) : 34'(rem_t);
            r_root[j] <= {root_in[30:0], ge};
            r_v[j]    <= {v_in[61:0], 2'b00};
        end
    end

    assign o_root = r_root[SQRT_STG-1];

endmodule

/* design/v2d_div_lane.sv */
// One divider lane: restoring division of a component by the length,
// one quotient bit per stage, FRAC_BITS + 1 stages. Depends on v2d_pkg.
module v2d_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic [31:0]        i_num,
    input  logic [31:0]        i_den,
    output logic [FRAC_BITS:0] o_q
);
    import v2d_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic [WORD_W-1:0] r_rem [QW];
    logic [WORD_W-1:0] r_den [QW];
    logic [QW-1:0]     r_q   [QW];

    // The numerator never exceeds the length, so the first bit needs no shift.
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [32:0] t;
        logic [31:0] den;
        logic [QW-1:0] q_in;
        logic        ge;
        if (j == 0) begin : g_first
            assign t    = {1'b0, i_num};
            assign den  = i_den;
            assign q_in = '0;
        end else begin : g_next
            assign t    = {r_rem[j-1], 1'b0};
            assign den  = r_den[j-1];
            assign q_in = r_q[j-1];
        end
        assign ge = t >= {1'b0, den};
        always_ff @(posedge i_clk) begin
            r_rem[j] <= ge ? 32'(t - {1'b0, den}) : t[31:0];
            r_den[j] <= den;
            r_q[j]   <= {q_in[QW-2:0], ge};
        end
    end

    assign o_q = r_q[QW-1];

endmodule

/* design/vector_2d_arith_unit.sv */
// Top level of the 2D vector unit: front stages, normalizing shift, square
// root, two divider lanes and the merge stage. Depends on v2d_pkg.
//
// Takes one input word per clock: busy is always low, so every cycle with
// start high accepts a word. The result word is driven on o_result with
// o_strobe high for exactly one cycle; both come from registers after the
// merge stage. The words come out in the order they went in. The path
// length is set by the front stages, the normalizing shift, the 32-stage
// square root, shared by length and normalize, and the FRAC_BITS + 1
// stages of the x and y divider lanes; every mode takes the same path
// length so results never overtake each other. The receiver cannot stall,
// and none is needed: the pipeline never holds a word back.
// Add, subtract and scale saturate to the 32-bit range and report it in
// status; normalizing a zero vector returns zeros with the zero status.
module vector_2d_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  v2d_pkg::t_in_word  i_item,
    output logic               busy,
    output logic               o_strobe,
    output v2d_pkg::t_out_word o_result
);
    import v2d_pkg::*;

    localparam int QW     = FRAC_BITS + 1;
    // Pipeline registers ahead of the merge stage.
    localparam int LAT    = 41 + FRAC_BITS;
    // Side data leaves the front two stages in; the root leaves at stage 40.
    localparam int SIDE_D = LAT - 2;
    localparam int MAG_D  = QW;
    localparam int NUM_D  = SQRT_STG;

    t_mag        front_mag;
    t_side       front_side;
    t_mag        prep_mag;
    logic [63:0] prep_sum;
    logic [31:0] root;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;

    logic [LAT-1:0] r_vld;
    t_side       r_side [SIDE_D];
    logic [31:0] r_magd [MAG_D];
    t_mag        r_num  [NUM_D];
    logic        r_strobe;
    t_out_word   r_result;
    t_out_word   n_result;
    t_side       side;
    logic [31:0] ux;
    logic [31:0] uy;

    v2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk  (i_clk),
        .i_item (i_item),
        .o_mag  (front_mag),
        .o_side (front_side)
    );

    v2d_prep u_prep (
        .i_clk (i_clk),
        .i_mag (front_mag),
        .o_mag (prep_mag),
        .o_sum (prep_sum)
    );

    v2d_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_v    (prep_sum),
        .o_root (root)
    );

    v2d_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_num (r_num[NUM_D-1].mx),
        .i_den (root),
        .o_q   (qx)
    );

    v2d_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_num (r_num[NUM_D-1].my),
        .i_den (root),
        .o_q   (qy)
    );

    // Valid bits travel alongside the data; only they need a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[LAT-2:0], start};
            r_strobe <= r_vld[LAT-1];
        end
    end

    // Delay lines that keep side data, the root and the shifted components
    // aligned with the stage that consumes them.
    always_ff @(posedge i_clk) begin
        r_side[0] <= front_side;
        for (int i = 1; i < SIDE_D; i++) begin
            r_side[i] <= r_side[i-1];
        end
        r_magd[0] <= root;
        for (int i = 1; i < MAG_D; i++) begin
            r_magd[i] <= r_magd[i-1];
        end
        r_num[0] <= prep_mag;
        for (int i = 1; i < NUM_D; i++) begin
            r_num[i] <= r_num[i-1];
        end
    end

    assign side = r_side[SIDE_D-1];
    assign ux   = {{(WORD_W - QW){1'b0}}, qx};
    assign uy   = {{(WORD_W - QW){1'b0}}, qy};

    // Merge: pick the lane results that belong to the word's mode.
    always_comb begin
        n_result.res_x     = side.res_x;
        n_result.res_y     = side.res_y;
        n_result.magnitude = '0;
        n_result.status    = side.status;
        unique case (side.mode)
            MODE_LEN: begin
                n_result.magnitude = r_magd[MAG_D-1];
            end
            MODE_NORM: begin
                if (side.zero) begin
                    n_result.res_x  = '0;
                    n_result.res_y  = '0;
                    n_result.status = ST_ZERO;
                end else begin
                    n_result.res_x  = side.sx ? (~ux + 32'd1) : ux;
                    n_result.res_y  = side.sy ? (~uy + 32'd1) : uy;
                    n_result.status = ST_OK;
                end
            end
            default: begin
                n_result.magnitude = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
